/* hw/rtl/ffca_pkg.sv */
// ----------------------------------------------------------------------------
// ffca_pkg
// shared status codes and constants of the first-fit canary allocator
// ----------------------------------------------------------------------------
package ffca_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_DOUBLE   = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    // canary slot after every block except the tail
    localparam int unsigned SLOT_BYTES  = 8;
    localparam logic [31:0] HEAP_RESET  = 32'd4096;
    localparam int unsigned FIELD_BITS  = 32;
    localparam int unsigned CANARY_BITS = 64;

endpackage

/* hw/rtl/ffca_table.sv */
// ----------------------------------------------------------------------------
// ffca_table
// segment table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ffca_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 170,
    parameter int IW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [IW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/first_fit_canary_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_canary_allocator_top
// first-fit heap allocator with canary slots and coalescing of free segments
// ----------------------------------------------------------------------------
// One item at a time: s_ready is high only while the sequencer is idle. The
// segment list lives in a table memory with one write and one read port and is
// walked one entry at a time (address, then registered read data). An allocate
// walks to the first fit, then scans for a spare entry when the fit is split.
// A free walks the list to find the block, then walks it again to merge. A
// finished result waits in the output register, so the next item is taken
// while it is still unclaimed. heap_bytes (byte address 0) is read only when
// the first allocate creates the heap; later writes do not change the heap,
// and a reset restores HEAP_RESET.
// ----------------------------------------------------------------------------
module first_fit_canary_allocator_top
    import ffca_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [31:0]        s_request_size,
    input  logic [31:0]        s_free_address,
    input  logic signed [63:0] s_new_canary,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [31:0]        m_block_address,
    output logic [31:0]        m_block_size,
    output logic [31:0]        m_canary_address,
    output logic signed [63:0] m_canary_value
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LW = IW + 1;
    localparam int AW = ADDR_BITS;
    // compare width: holds request + slot and any stored offset
    localparam int CW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
    localparam logic [LW-1:0] END_LINK = LW'(MAX_SEGMENTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SEGMENTS - 1);

    typedef struct packed {
        logic [AW-1:0]          start;
        logic [AW-1:0]          size;
        logic                   busy;
        logic [CANARY_BITS-1:0] canary;
        logic [LW-1:0]          link;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_FIND,
        S_SCAN,
        S_SPLIT,
        S_COMMIT,
        S_LOOK,
        S_MRG_A,
        S_MRG_B,
        S_FIN
    } state_t;

    // control
    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    logic [MAX_SEGMENTS-1:0] in_use_reg, in_use_next;
    logic                   heap_ready_reg, heap_ready_next;
    logic [31:0]            heap_bytes_reg, heap_bytes_next;
    logic                   m_valid_reg, m_valid_next;

    // working registers
    logic [31:0]            req_reg, req_next;
    logic [CW-1:0]          req8_reg, req8_next;
    logic [31:0]            addr_reg, addr_next;
    logic [CANARY_BITS-1:0] canary_reg, canary_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          nx_reg, nx_next;
    logic [IW-1:0]          spare_reg, spare_next;
    logic [IW-1:0]          rd_addr_reg, rd_addr_next;
    logic [LW-1:0]          steps_reg, steps_next;
    entry_t                 cur_reg, cur_next;

    // pending result and output register
    status_t                res_status_reg, res_status_next;
    logic [31:0]            res_baddr_reg, res_baddr_next;
    logic [31:0]            res_bsize_reg, res_bsize_next;
    logic [31:0]            res_caddr_reg, res_caddr_next;
    logic [CANARY_BITS-1:0] res_cval_reg, res_cval_next;
    status_t                out_status_reg, out_status_next;
    logic [31:0]            out_baddr_reg, out_baddr_next;
    logic [31:0]            out_bsize_reg, out_bsize_next;
    logic [31:0]            out_caddr_reg, out_caddr_next;
    logic [CANARY_BITS-1:0] out_cval_reg, out_cval_next;

    // table port
    logic                   mem_we;
    logic [IW-1:0]          mem_wa;
    entry_t                 mem_wd;
    logic [EW-1:0]          mem_rd;
    entry_t                 rd_q;

    // widened views for the add / compare
    logic [CW-1:0]          rd_start_x, rd_size_x, cur_start_x, cur_size_x;
    logic [CW-1:0]          addr_x, heap_x, mask_x, heap_sat_x;
    logic [CW-1:0]          sum_a, sum_b, sum_c;
    logic                   last_visit;
    logic                   cfg_wr;

    ffca_table #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW),
        .IW    (IW)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (rd_addr_reg),
        .rdata (mem_rd)
    );

    assign rd_q        = entry_t'(mem_rd);
    assign rd_start_x  = CW'(rd_q.start);
    assign rd_size_x   = CW'(rd_q.size);
    assign cur_start_x = CW'(cur_reg.start);
    assign cur_size_x  = CW'(cur_reg.size);
    assign addr_x      = CW'(addr_reg);
    assign heap_x      = CW'(heap_bytes_reg);
    assign mask_x      = (CW'(1) << AW) - CW'(1);
    // heap size saturates to the addressable range
    assign heap_sat_x  = (heap_x > mask_x) ? mask_x : heap_x;
    assign last_visit  = (steps_reg + LW'(1)) == END_LINK;
    assign sum_a       = rd_start_x + rd_size_x;
    assign sum_b       = cur_start_x + req8_reg;
    assign sum_c       = cur_start_x + CW'(req_reg);

    // configuration port: register 0 is heap_bytes, bit 2 of paddr selects beyond it
    assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? 32'd0 : heap_bytes_reg;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = out_status_reg;
    assign m_block_address  = out_baddr_reg;
    assign m_block_size     = out_bsize_reg;
    assign m_canary_address = out_caddr_reg;
    assign m_canary_value   = out_cval_reg;

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        in_use_next     = in_use_reg;
        heap_ready_next = heap_ready_reg;
        heap_bytes_next = heap_bytes_reg;
        m_valid_next    = m_valid_reg;
        req_next        = req_reg;
        req8_next       = req8_reg;
        addr_next       = addr_reg;
        canary_next     = canary_reg;
        idx_next        = idx_reg;
        nx_next         = nx_reg;
        spare_next      = spare_reg;
        rd_addr_next    = rd_addr_reg;
        steps_next      = steps_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_baddr_next  = res_baddr_reg;
        res_bsize_next  = res_bsize_reg;
        res_caddr_next  = res_caddr_reg;
        res_cval_next   = res_cval_reg;
        out_status_next = out_status_reg;
        out_baddr_next  = out_baddr_reg;
        out_bsize_next  = out_bsize_reg;
        out_caddr_next  = out_caddr_reg;
        out_cval_next   = out_cval_reg;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = cur_reg;

        if (cfg_wr) begin
            heap_bytes_next = pwdata;
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_request_size;
                    req8_next       = CW'(s_request_size) + CW'(SLOT_BYTES);
                    addr_next       = s_free_address;
                    canary_next     = s_new_canary;
                    res_status_next = ST_OK;
                    res_baddr_next  = '0;
                    res_bsize_next  = '0;
                    res_caddr_next  = '0;
                    res_cval_next   = '0;
                    idx_next        = '0;
                    rd_addr_next    = '0;
                    steps_next      = '0;
                    if (!s_mode) begin
                        if (s_request_size == 32'd0) begin
                            res_status_next = ST_ZERO;
                            state_next      = S_FIN;
                        end else begin
                            // first allocate creates one free segment over the heap
                            if (!heap_ready_reg) begin
                                mem_we          = 1'b1;
                                mem_wa          = '0;
                                mem_wd.start    = '0;
                                mem_wd.size     = heap_sat_x[AW-1:0];
                                mem_wd.busy     = 1'b0;
                                mem_wd.canary   = '0;
                                mem_wd.link     = END_LINK;
                                in_use_next[0]  = 1'b1;
                                heap_ready_next = 1'b1;
                            end
                            ret_next   = S_FIND;
                            state_next = S_RD;
                        end
                    end else begin
                        res_baddr_next = s_free_address;
                        if (!heap_ready_reg) begin
                            res_status_next = ST_NOTFOUND;
                            state_next      = S_FIN;
                        end else begin
                            ret_next   = S_LOOK;
                            state_next = S_RD;
                        end
                    end
                end
            end

            S_RD: begin
                state_next = ret_reg;
            end

            // first-fit walk
            S_FIND: begin
                cur_next   = rd_q;
                steps_next = steps_reg + LW'(1);
                if (!rd_q.busy && rd_size_x >= req8_reg) begin
                    if (rd_size_x == req8_reg) begin
                        state_next = S_COMMIT;
                    end else begin
                        spare_next = '0;
                        state_next = S_SCAN;
                    end
                end else if (rd_q.link == END_LINK || last_visit) begin
                    res_status_next = ST_NOFIT;
                    state_next      = S_FIN;
                end else begin
                    idx_next     = rd_q.link[IW-1:0];
                    rd_addr_next = rd_q.link[IW-1:0];
                    state_next   = S_RD;
                end
            end

            // look for an unused table entry, one per cycle
            S_SCAN: begin
                if (!in_use_reg[spare_reg]) begin
                    state_next = S_SPLIT;
                end else if (spare_reg == LAST_IDX) begin
                    res_status_next = ST_FULL;
                    state_next      = S_FIN;
                end else begin
                    spare_next = spare_reg + IW'(1);
                end
            end

            S_SPLIT: begin
                mem_we                 = 1'b1;
                mem_wa                 = spare_reg;
                mem_wd.start           = sum_b[AW-1:0];
                mem_wd.size            = AW'(cur_size_x - req8_reg);
                mem_wd.busy            = 1'b0;
                mem_wd.canary          = '0;
                mem_wd.link            = cur_reg.link;
                in_use_next[spare_reg] = 1'b1;
                cur_next.link          = LW'(spare_reg);
                state_next             = S_COMMIT;
            end

            S_COMMIT: begin
                mem_we          = 1'b1;
                mem_wa          = idx_reg;
                mem_wd.start    = cur_reg.start;
                mem_wd.size     = AW'(req_reg);
                mem_wd.busy     = 1'b1;
                mem_wd.canary   = canary_reg;
                mem_wd.link     = cur_reg.link;
                res_status_next = ST_OK;
                res_baddr_next  = cur_start_x[31:0];
                res_bsize_next  = req_reg;
                res_caddr_next  = sum_c[31:0];
                res_cval_next   = canary_reg;
                state_next      = S_FIN;
            end

            // search for the block to free
            S_LOOK: begin
                steps_next = steps_reg + LW'(1);
                if (rd_start_x == addr_x) begin
                    res_bsize_next = rd_size_x[31:0];
                    if (!rd_q.busy) begin
                        res_status_next = ST_DOUBLE;
                        state_next      = S_FIN;
                    end else begin
                        res_status_next = ST_OK;
                        res_caddr_next  = sum_a[31:0];
                        res_cval_next   = rd_q.canary;
                        mem_we          = 1'b1;
                        mem_wa          = idx_reg;
                        mem_wd          = rd_q;
                        mem_wd.busy     = 1'b0;
                        idx_next        = '0;
                        rd_addr_next    = '0;
                        ret_next        = S_MRG_A;
                        state_next      = S_RD;
                    end
                end else if (rd_q.link == END_LINK || last_visit) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_FIN;
                end else begin
                    idx_next     = rd_q.link[IW-1:0];
                    rd_addr_next = rd_q.link[IW-1:0];
                    state_next   = S_RD;
                end
            end

            // merge walk: outer entry
            S_MRG_A: begin
                cur_next = rd_q;
                if (rd_q.link == END_LINK) begin
                    state_next = S_FIN;
                end else if (rd_q.busy) begin
                    idx_next     = rd_q.link[IW-1:0];
                    rd_addr_next = rd_q.link[IW-1:0];
                    state_next   = S_RD;
                end else begin
                    nx_next      = rd_q.link[IW-1:0];
                    rd_addr_next = rd_q.link[IW-1:0];
                    ret_next     = S_MRG_B;
                    state_next   = S_RD;
                end
            end

            // merge walk: follower of a free entry
            S_MRG_B: begin
                if (!rd_q.busy) begin
                    // tail segment brings no canary slot
                    cur_next.size = cur_reg.size + rd_q.size
                                    + ((rd_q.link != END_LINK) ? AW'(SLOT_BYTES) : AW'(0));
                    cur_next.link       = rd_q.link;
                    mem_we              = 1'b1;
                    mem_wa              = idx_reg;
                    mem_wd              = cur_next;
                    in_use_next[nx_reg] = 1'b0;
                    if (rd_q.link == END_LINK) begin
                        state_next = S_FIN;
                    end else begin
                        nx_next      = rd_q.link[IW-1:0];
                        rd_addr_next = rd_q.link[IW-1:0];
                        state_next   = S_RD;
                    end
                end else if (rd_q.link == END_LINK) begin
                    state_next = S_FIN;
                end else begin
                    idx_next     = rd_q.link[IW-1:0];
                    rd_addr_next = rd_q.link[IW-1:0];
                    ret_next     = S_MRG_A;
                    state_next   = S_RD;
                end
            end

            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_baddr_next  = res_baddr_reg;
                    out_bsize_next  = res_bsize_reg;
                    out_caddr_next  = res_caddr_reg;
                    out_cval_next   = res_cval_reg;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            in_use_reg     <= '0;
            heap_ready_reg <= 1'b0;
            heap_bytes_reg <= HEAP_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            in_use_reg     <= in_use_next;
            heap_ready_reg <= heap_ready_next;
            heap_bytes_reg <= heap_bytes_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        req8_reg       <= req8_next;
        addr_reg       <= addr_next;
        canary_reg     <= canary_next;
        idx_reg        <= idx_next;
        nx_reg         <= nx_next;
        spare_reg      <= spare_next;
        rd_addr_reg    <= rd_addr_next;
        steps_reg      <= steps_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_baddr_reg  <= res_baddr_next;
        res_bsize_reg  <= res_bsize_next;
        res_caddr_reg  <= res_caddr_next;
        res_cval_reg   <= res_cval_next;
        out_status_reg <= out_status_next;
        out_baddr_reg  <= out_baddr_next;
        out_bsize_reg  <= out_bsize_next;
        out_caddr_reg  <= out_caddr_next;
        out_cval_reg   <= out_cval_next;
    end

endmodule

/* hw/rtl/ffca_checker.sv */
// ----------------------------------------------------------------------------
// ffca_checker
// port-level checks of the first-fit canary allocator
// ----------------------------------------------------------------------------
module ffca_checker
    import ffca_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_status,
    input logic [31:0]        m_block_address,
    input logic [31:0]        m_block_size,
    input logic [31:0]        m_canary_address,
    input logic signed [63:0] m_canary_value
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_NOTFOUND)
        else $error("undefined status");

    a_canary_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK
            |-> m_canary_address == 32'(m_block_address + m_block_size))
        else $error("canary slot not after block");

    a_zero_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ZERO || m_status == ST_NOFIT || m_status == ST_FULL)
            |-> m_block_address == 32'd0 && m_block_size == 32'd0
                && m_canary_value == 64'sd0)
        else $error("error result carries data");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_block_address))
        else $error("result dropped while stalled");

endmodule

bind first_fit_canary_allocator_top ffca_checker u_ffca_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit canary allocator: a heap model in the
// bench predicts every result, and the result items are compared field by field
// ----------------------------------------------------------------------------
module tb_top;
    import ffca_pkg::*;

    localparam int SEGS       = 64;
    localparam int END_LINK   = SEGS;
    // walk of the list plus spare scan or merge walk, with margin
    localparam int SETTLE_CYC = 4 * SEGS + 40;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct {
        status_t     status;
        logic [31:0] address;
        logic [31:0] size;
        logic [31:0] canary_addr;
        logic [63:0] canary;
    } alloc_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic [31:0]        s_request_size = '0;
    logic [31:0]        s_free_address = '0;
    logic signed [63:0] s_new_canary = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic [31:0]        m_block_address;
    logic [31:0]        m_block_size;
    logic [31:0]        m_canary_address;
    logic signed [63:0] m_canary_value;

    // heap model: segment table linked in address order, entry 0 is the head
    logic [63:0] seg_base_m [SEGS];
    logic [63:0] seg_len_m  [SEGS];
    logic        seg_held_m [SEGS];
    logic [63:0] seg_guard_m[SEGS];
    int          seg_next_m [SEGS];
    logic        seg_taken_m[SEGS];
    logic        heap_built;
    logic [31:0] heap_cfg;

    alloc_result_t pending_results[$];
    int mismatches = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    longint cycles = 0;

    first_fit_canary_allocator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_request_size(s_request_size), .s_free_address(s_free_address),
        .s_new_canary(s_new_canary),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_block_address(m_block_address), .m_block_size(m_block_size),
        .m_canary_address(m_canary_address), .m_canary_value(m_canary_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver back-pressure, percentage set per phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // heap model
    // ------------------------------------------------------------------
    function automatic void coalesce_free_runs();
        int idx = 0;
        int steps = 0;
        int nx;
        while (idx < SEGS && steps <= 2 * SEGS) begin
            steps++;
            if (!seg_held_m[idx]) begin
                nx = seg_next_m[idx];
                while (nx < SEGS && !seg_held_m[nx] && steps <= 2 * SEGS) begin
                    steps++;
                    // the tail has no canary slot to absorb
                    seg_len_m[idx] += seg_len_m[nx] + ((seg_next_m[nx] < SEGS) ? SLOT_BYTES : 0);
                    seg_next_m[idx] = seg_next_m[nx];
                    seg_taken_m[nx] = 1'b0;
                    nx = seg_next_m[idx];
                end
            end
            idx = seg_next_m[idx];
        end
    endfunction

    function automatic alloc_result_t model_alloc(logic [31:0] req, logic [63:0] guard);
        alloc_result_t r = '{ST_OK, 0, 0, 0, 0};
        int idx = 0;
        int steps = 0;
        int spare = END_LINK;
        logic [63:0] need = {32'd0, req} + SLOT_BYTES;
        logic [63:0] rem;
        if (req == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        if (!heap_built) begin
            seg_base_m[0] = 0;
            seg_len_m[0] = {32'd0, heap_cfg};
            seg_held_m[0] = 1'b0;
            seg_guard_m[0] = 0;
            seg_next_m[0] = END_LINK;
            seg_taken_m[0] = 1'b1;
            heap_built = 1'b1;
        end
        while (idx < SEGS && steps < SEGS) begin
            steps++;
            if (!seg_held_m[idx] && seg_len_m[idx] >= need) break;
            idx = seg_next_m[idx];
        end
        if (idx >= SEGS || seg_held_m[idx] || seg_len_m[idx] < need) begin
            r.status = ST_NOFIT;
            return r;
        end
        rem = seg_len_m[idx] - need;
        if (rem > 0) begin
            for (int i = 0; i < SEGS; i++) begin
                if (!seg_taken_m[i]) begin
                    spare = i;
                    break;
                end
            end
            if (spare >= SEGS) begin
                r.status = ST_FULL;
                return r;
            end
            seg_base_m[spare] = seg_base_m[idx] + need;
            seg_len_m[spare] = rem;
            seg_held_m[spare] = 1'b0;
            seg_guard_m[spare] = 0;
            seg_next_m[spare] = seg_next_m[idx];
            seg_taken_m[spare] = 1'b1;
            seg_next_m[idx] = spare;
        end
        seg_len_m[idx] = {32'd0, req};
        seg_held_m[idx] = 1'b1;
        seg_guard_m[idx] = guard;
        r.address = seg_base_m[idx][31:0];
        r.size = req;
        r.canary_addr = seg_base_m[idx][31:0] + req;
        r.canary = guard;
        return r;
    endfunction

    function automatic alloc_result_t model_free(logic [31:0] addr);
        alloc_result_t r = '{ST_NOTFOUND, 0, 0, 0, 0};
        int idx = 0;
        int steps = 0;
        r.address = addr;
        if (!heap_built) return r;
        while (idx < SEGS && steps < SEGS) begin
            steps++;
            if (seg_base_m[idx] == {32'd0, addr}) begin
                r.size = seg_len_m[idx][31:0];
                if (!seg_held_m[idx]) begin
                    r.status = ST_DOUBLE;
                    return r;
                end
                r.status = ST_OK;
                r.canary_addr = seg_base_m[idx][31:0] + seg_len_m[idx][31:0];
                r.canary = seg_guard_m[idx];
                seg_held_m[idx] = 1'b0;
                coalesce_free_runs();
                return r;
            end
            idx = seg_next_m[idx];
        end
        return r;
    endfunction

    // random segment start of the wanted kind, from the live list
    function automatic bit pick_segment(bit want_busy, output logic [31:0] addr,
                                        output logic [63:0] len);
        logic [31:0] hits[$];
        logic [63:0] lens[$];
        int idx = 0;
        int steps = 0;
        int k;
        addr = 0;
        len = 0;
        if (!heap_built) return 0;
        while (idx < SEGS && steps < SEGS) begin
            steps++;
            if (seg_held_m[idx] == want_busy) begin
                hits.push_back(seg_base_m[idx][31:0]);
                lens.push_back(seg_len_m[idx]);
            end
            idx = seg_next_m[idx];
        end
        if (hits.size() == 0) return 0;
        k = $urandom_range(0, hits.size() - 1);
        addr = hits[k];
        len = lens[k];
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_request(bit mode, logic [31:0] req, logic [31:0] addr,
                                logic [63:0] guard);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            while ($urandom_range(0, 99) < idle_pct) @(posedge aclk);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_request_size <= req;
        s_free_address <= addr;
        s_new_canary <= guard;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        // item taken at this edge: predict now
        if (mode) pending_results.push_back(model_free(addr));
        else pending_results.push_back(model_alloc(req, guard));
    endtask

    task automatic alloc_bytes(logic [31:0] req);
        send_request(1'b0, req, $urandom, {$urandom, $urandom});
    endtask

    task automatic free_block(logic [31:0] addr);
        send_request(1'b1, $urandom, addr, {$urandom, $urandom});
    endtask

    // sender holds off until every result is in, then lets the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_heap_bytes(logic [31:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // only counts while the heap does not exist yet
        if (!heap_built) heap_cfg = value;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", m_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_block_address !== want.address)
                    report_mismatch("block_address", m_block_address, want.address);
                if (m_block_size !== want.size)
                    report_mismatch("block_size", m_block_size, want.size);
                if (m_canary_address !== want.canary_addr)
                    report_mismatch("canary_address", m_canary_address, want.canary_addr);
                if (m_canary_value !== want.canary)
                    report_mismatch("canary_value", m_canary_value, want.canary);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_register_extremes();
        write_heap_bytes(32'd16);
        write_heap_bytes(32'hFFFF_FFFF);
        write_heap_bytes(32'd3000);
    endtask

    // frees and zero-size requests before the heap exists
    task automatic test_before_heap();
        free_block(32'd0);
        free_block(32'hFFFF_FFFF);
        alloc_bytes(32'd0);
        free_block(32'd0);
    endtask

    task automatic test_directed();
        logic [31:0] a;
        logic [63:0] len;
        alloc_bytes(32'hFFFF_FFFF);          // no fit, creates the heap
        send_request(1'b0, 32'd1, 0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(1'b0, 32'd100, 0, 64'h8000_0000_0000_0000);
        alloc_bytes(32'd0);
        free_block(32'd0);                   // neighbour busy, no merge
        free_block(32'd0);                   // double free
        free_block(32'd5);                   // not found
        free_block(32'd9);                   // merges with head and tail
        // whole heap free again: exact fit leaves no remainder
        if (pick_segment(1'b0, a, len)) alloc_bytes(len[31:0] - SLOT_BYTES);
        alloc_bytes(32'd1);                  // no fit
        free_block(32'd0);
        alloc_bytes(32'd2993);               // one byte too many for the 3000-byte heap
        drain_results();
        write_heap_bytes(32'd16);            // late write, heap already built
    endtask

    // fill the table with tiny blocks until a split has no spare entry
    task automatic test_table_full();
        logic [31:0] a;
        logic [63:0] len;
        for (int n = 0; n < SEGS + 2; n++) alloc_bytes(32'd4);
        alloc_bytes(32'd8);
        while (pick_segment(1'b1, a, len)) free_block(a);
        drain_results();
    endtask

    task automatic test_random_phase(int items);
        logic [31:0] a;
        logic [63:0] len;
        int pick;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                alloc_bytes(($urandom_range(0, 9) == 0) ? $urandom_range(1, 400)
                                                       : $urandom_range(1, 40));
            end else if (pick < 52 && pick_segment(1'b0, a, len) && len > SLOT_BYTES) begin
                alloc_bytes(len[31:0] - SLOT_BYTES);
            end else if (pick < 85 && pick_segment(1'b1, a, len)) begin
                free_block(a);
            end else if (pick < 90 && pick_segment(1'b0, a, len)) begin
                free_block(a);
            end else if (pick < 95) begin
                free_block($urandom);
            end else begin
                alloc_bytes(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        heap_built = 1'b0;
        heap_cfg = HEAP_RESET;
        for (int i = 0; i < SEGS; i++) seg_taken_m[i] = 1'b0;

        test_register_extremes();
        test_before_heap();
        test_directed();
        test_table_full();

        // no idling, sender idle, receiver stalling, both
        idle_pct = 0;  stall_pct = 0;  test_random_phase(370);
        write_heap_bytes($urandom);
        idle_pct = 64; stall_pct = 0;  test_random_phase(370);
        drain_results();
        idle_pct = 0;  stall_pct = 64; test_random_phase(370);
        write_heap_bytes(32'hFFFF_FFFF);
        idle_pct = 31; stall_pct = 31; test_random_phase(370);

        drain_results();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
